// File: design/rpsd_pkg.sv
// Package: shared types, constants and command codes for the running stddev unit
`timescale 1ns / 1ps
package rpsd_pkg;
	localparam int POINTS_DEF = 4096;
	localparam int COUNT_BITS_DEF = 16;
	localparam int IDX_W = 12;
	localparam int SAMPLE_W = 32;
	localparam int MEAN_W = 48;
	localparam int SUM_W = 64;
	localparam int SD_W = 32;

	typedef enum logic [1:0] {
		CMD_UPDATE  = 2'd0,
		CMD_READ    = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_FEW  = 2'd1,
		ST_SAT      = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [IDX_W-1:0] point_index;
		logic [SAMPLE_W-1:0] sample_value;
		logic        member_last;
	} in_item_t;

	typedef struct packed {
		logic [SD_W-1:0] std_dev;
		logic [IDX_W-1:0] result_index;
		logic [1:0]  status;
	} out_item_t;
endpackage

// File: design/rpsd_if.sv
// Interfaces: valid/ready channels for input items and result items
`timescale 1ns / 1ps
interface rpsd_in_if;
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [11:0] point_index;
	logic signed [31:0] sample_value;
	logic member_last;
	modport source (output valid, command, point_index, sample_value, member_last,
		input ready);
	modport sink (input valid, command, point_index, sample_value, member_last,
		output ready);
endinterface

interface rpsd_out_if;
	logic valid;
	logic ready;
	logic [31:0] std_dev;
	logic [11:0] result_index;
	logic [1:0] status;
	modport source (output valid, std_dev, result_index, status, input ready);
	modport sink (input valid, std_dev, result_index, status, output ready);
endinterface

// File: design/rpsd_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module rpsd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: design/rpsd_fifo.sv
// Two-entry queue between the front end and the compute engine
`timescale 1ns / 1ps
module rpsd_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rpsd_pkg::in_item_t din,
	output logic full,
	input  logic pop,
	output logic empty,
	output rpsd_pkg::in_item_t dout
);
	import rpsd_pkg::*;
	in_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout = mem_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: design/rpsd_front.sv
// Front end: accepts items, drops unused commands, tracks member count
`timescale 1ns / 1ps
module rpsd_front #(
	parameter int COUNT_BITS = rpsd_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rpsd_in_if.sink in_ch,
	input  logic q_full,
	output logic q_push,
	output rpsd_pkg::in_item_t q_din,
	output logic [COUNT_BITS:0] q_n
);
	import rpsd_pkg::*;
	// count travels with each item: n = members done before it (+1 applied in back)
	logic [COUNT_BITS-1:0] count_q;
	logic acc;
	assign in_ch.ready = !q_full;
	assign acc = in_ch.valid && in_ch.ready;
	assign q_din = '{command: in_ch.command, point_index: in_ch.point_index,
		sample_value: in_ch.sample_value, member_last: in_ch.member_last};
	assign q_push = acc && (in_ch.command == CMD_UPDATE || in_ch.command == CMD_READ);
	assign q_n = {1'b0, count_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			if (in_ch.command == CMD_RESTART) count_q <= '0;
			else if (in_ch.command == CMD_UPDATE && in_ch.member_last && !(&count_q))
				count_q <= count_q + 1'b1;
		end
	end
endmodule

// File: design/rpsd_back.sv
// Back end: per-point Welford update and standard deviation read-out
`timescale 1ns / 1ps
module rpsd_back #(
	parameter int POINTS = rpsd_pkg::POINTS_DEF,
	parameter int COUNT_BITS = rpsd_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  rpsd_pkg::in_item_t q_dout,
	input  logic [COUNT_BITS:0] q_n,
	output logic q_pop,
	rpsd_out_if.source out_ch
);
	import rpsd_pkg::*;
	localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int CW = COUNT_BITS + 1;
	localparam int PW = 49;   // |pert| magnitude bits (Q33.16)
	localparam int TW = 100;  // pert^2, and its integer part (Q66.0) times the count

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_LOAD, S_ABS, S_SQ, S_SCALE, S_TDIV, S_MDIV, S_WR,
		S_VDIV, S_SQRT, S_OUT
	} state_t;
	state_t state_q;

	in_item_t item_q;
	logic [CW-1:0] n_q;
	logic in_range;
	logic [MEAN_W-1:0] mean_rd, mean_wd;
	logic [SUM_W-1:0] sum_rd, sum_wd;
	logic we;
	logic [AW-1:0] addr;

	rpsd_ram #(.WIDTH(MEAN_W), .DEPTH(POINTS), .AW(AW)) u_mean (
		.clk(clk), .we(we), .addr(addr), .wdata(mean_wd), .rdata(mean_rd));
	rpsd_ram #(.WIDTH(SUM_W), .DEPTH(POINTS), .AW(AW)) u_sum (
		.clk(clk), .we(we), .addr(addr), .wdata(sum_wd), .rdata(sum_rd));

	assign addr = AW'(item_q.point_index);
	assign in_range = {20'd0, item_q.point_index} < 32'(POINTS);

	logic signed [PW:0] pert_q;
	logic [PW-1:0] ap_q;
	logic [TW-1:0] t_q;       // divider dividend, shifted out from the top
	logic [TW-1:0] quo_q;
	logic [CW+1:0] rem_q;
	logic [TW-1:0] mc_q;      // multiplicand, shifted left each step
	logic [PW-1:0] mp_q;      // multiplier, shifted right each step
	logic [TW-1:0] acc_q;
	logic [7:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [PW-1:0] aq_q;      // |pert|/n
	logic [SUM_W-1:0] term_q;
	logic [SD_W-1:0] sd_q;
	logic [1:0] st_q;
	logic [SD_W-1:0] res_sd_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [1:0] res_st_q;
	logic out_v_q;
	// sqrt registers
	logic [SUM_W-1:0] sv_q, res_q, bit_q;

	logic [CW-1:0] div_d;
	logic [CW+1:0] rsh;
	logic div_ge;
	logic [PW-1:0] ap_nx;
	logic take, out_load;

	assign out_ch.valid = out_v_q;
	assign out_ch.std_dev = res_sd_q;
	assign out_ch.result_index = res_idx_q;
	assign out_ch.status = res_st_q;

	// restoring divider, one quotient bit per cycle
	assign rsh = {rem_q[CW:0], t_q[TW-1]};
	assign div_ge = rsh >= {2'b0, div_d};
	assign ap_nx = pert_q[PW] ? PW'(-pert_q) : PW'(pert_q);
	assign take = (state_q == S_IDLE) && !q_empty;
	// output register frees the engine while the receiver stalls
	assign out_load = (state_q == S_OUT) && (!out_v_q || out_ch.ready);

	always_comb begin
		div_d = (item_q.command == CMD_READ) ? n_q - 1'b1 : n_q + 1'b1;
	end

	logic signed [MEAN_W+1:0] nm;
	always_comb begin
		nm = (MEAN_W+2)'(mean_q) + (pert_q[PW] ? -(MEAN_W+2)'(aq_q) : (MEAN_W+2)'(aq_q));
		if (nm > (MEAN_W+2)'(signed'({1'b0, {(MEAN_W-1){1'b1}}})))
			mean_wd = {1'b0, {(MEAN_W-1){1'b1}}};
		else if (nm < -(MEAN_W+2)'(signed'({1'b0, 1'b1, {(MEAN_W-1){1'b0}}})))
			mean_wd = {1'b1, {(MEAN_W-1){1'b0}}};
		else mean_wd = nm[MEAN_W-1:0];
		sum_wd = (n_q == '0) ? '0 :
			((~sum_q) < term_q ? '1 : sum_q + term_q);
	end
	assign we = (state_q == S_WR) && in_range;

	logic first_n;
	assign first_n = (n_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			q_pop <= 1'b0;
		end else begin
			q_pop <= take;
			out_v_q <= out_load || (out_v_q && !out_ch.ready);
			if (out_load) begin
				res_sd_q <= sd_q;
				res_idx_q <= item_q.point_index;
				res_st_q <= st_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						item_q <= q_dout;
						n_q <= q_n;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_LOAD; // RAM read latency
				S_LOAD: begin
					mean_q <= (first_n || !in_range) ? '0 : signed'(mean_rd);
					sum_q <= in_range ? sum_rd : '0;
					if (item_q.command == CMD_READ) begin
						if (n_q < CW'(2)) begin
							sd_q <= '0; st_q <= ST_TOO_FEW; state_q <= S_OUT;
						end else if (&sum_rd && in_range) begin
							sd_q <= '1; st_q <= ST_SAT; state_q <= S_OUT;
						end else begin
							t_q <= {(in_range ? sum_rd : {SUM_W{1'b0}}),
								{(TW-SUM_W){1'b0}}};
							rem_q <= '0; cnt_q <= 8'(SUM_W); state_q <= S_VDIV;
						end
					end else begin
						pert_q <= (PW+1)'(signed'({item_q.sample_value, 16'd0}))
							- (PW+1)'((first_n || !in_range) ? 48'sd0 : signed'(mean_rd));
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					ap_q <= ap_nx;
					mc_q <= TW'(ap_nx);
					mp_q <= ap_nx;
					acc_q <= '0; cnt_q <= 8'(PW); state_q <= S_SQ;
				end
				S_SQ: begin
					// shift-and-add square of |pert|
					if (cnt_q != 8'd0) begin
						if (mp_q[0]) acc_q <= acc_q + mc_q;
						mc_q <= {mc_q[TW-2:0], 1'b0};
						mp_q <= {1'b0, mp_q[PW-1:1]};
						cnt_q <= cnt_q - 8'd1;
					end else begin
						// integer part (Q66.0) of pert^2 times n-1 (members done so far)
						mc_q <= acc_q >> 32;
						mp_q <= PW'(n_q);
						acc_q <= '0; cnt_q <= 8'(CW); state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (cnt_q != 8'd0) begin
						if (mp_q[0]) acc_q <= acc_q + mc_q;
						mc_q <= {mc_q[TW-2:0], 1'b0};
						mp_q <= {1'b0, mp_q[PW-1:1]};
						cnt_q <= cnt_q - 8'd1;
					end else begin
						t_q <= acc_q;
						rem_q <= '0; cnt_q <= 8'(TW); state_q <= S_TDIV;
					end
				end
				S_TDIV: begin
					// spread term = scaled square / n
					if (cnt_q != 8'd0) begin
						rem_q <= div_ge ? rsh - {2'b0, div_d} : rsh;
						quo_q <= {quo_q[TW-2:0], div_ge};
						t_q <= {t_q[TW-2:0], 1'b0};
						cnt_q <= cnt_q - 8'd1;
					end else begin
						term_q <= (|quo_q[TW-1:SUM_W]) ? '1 : quo_q[SUM_W-1:0];
						t_q <= {ap_q, {(TW-PW){1'b0}}};
						rem_q <= '0; cnt_q <= 8'(PW); state_q <= S_MDIV;
					end
				end
				S_MDIV: begin
					// mean step = |pert| / n
					if (cnt_q != 8'd0) begin
						rem_q <= div_ge ? rsh - {2'b0, div_d} : rsh;
						quo_q <= {quo_q[TW-2:0], div_ge};
						t_q <= {t_q[TW-2:0], 1'b0};
						cnt_q <= cnt_q - 8'd1;
					end else begin
						aq_q <= quo_q[PW-1:0];
						state_q <= S_WR;
					end
				end
				S_WR: begin
					state_q <= S_IDLE;
				end
				S_VDIV: begin
					if (cnt_q != 8'd0) begin
						rem_q <= div_ge ? rsh - {2'b0, div_d} : rsh;
						quo_q <= {quo_q[TW-2:0], div_ge};
						t_q <= {t_q[TW-2:0], 1'b0};
						cnt_q <= cnt_q - 8'd1;
					end else begin
						sv_q <= quo_q[SUM_W-1:0];
						res_q <= '0; bit_q <= 64'h4000_0000_0000_0000;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q != 0) begin
						if (sv_q >= res_q + bit_q) begin
							sv_q <= sv_q - (res_q + bit_q);
							res_q <= (res_q >> 1) + bit_q;
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end else begin
						sd_q <= res_q[SD_W-1:0]; st_q <= ST_OK; state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: design/running_pointwise_stddev_unit.sv
// Top level: running per-point mean and standard deviation unit
`timescale 1ns / 1ps
// Welford running variance per point over ensemble members. Only reads return
// a beat. The front end keeps the member count and finishes restart and unused
// commands in the cycle they are accepted; updates and reads pass a two-entry
// queue to the back end, which works on one item at a time. Between its RAM read
// and write an update runs a 49-step square, a scaling by the count, a 100-step
// divide for the spread term and a 49-step divide for the mean step; a read runs
// a 64-step divide and a 32-step square root before its beat, and a read that
// ends in too-few or saturated status goes to its beat straight from the load.
// One output register holds a finished result, so the back end waits only when
// a second result is ready before the first was taken; the input stalls while
// the queue is full.
module running_pointwise_stddev_unit #(
	parameter int POINTS = rpsd_pkg::POINTS_DEF,
	parameter int COUNT_BITS = rpsd_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rpsd_in_if.sink in_ch,
	rpsd_out_if.source out_ch
);
	import rpsd_pkg::*;
	logic q_push, q_full, q_pop, q_empty;
	in_item_t q_din, q_dout;
	logic [COUNT_BITS:0] n_in;
	logic [COUNT_BITS:0] n_q [2];
	logic nwp_q, nrp_q;

	rpsd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .q_full(q_full),
		.q_push(q_push), .q_din(q_din), .q_n(n_in));
	rpsd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(q_din), .full(q_full),
		.pop(q_pop), .empty(q_empty), .dout(q_dout));

	// member count travels beside the queue
	always_ff @(posedge clk) begin
		if (q_push) n_q[nwp_q] <= n_in;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nwp_q <= 1'b0; nrp_q <= 1'b0;
		end else begin
			if (q_push) nwp_q <= ~nwp_q;
			if (q_pop) nrp_q <= ~nrp_q;
		end
	end

	rpsd_back #(.POINTS(POINTS), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_dout(q_dout),
		.q_n(n_q[nrp_q]), .q_pop(q_pop), .out_ch(out_ch));
endmodule

// File: tb/rpsd_stddev_checker.sv
// Checker: watches both channels, predicts std-dev results and compares them
`timescale 1ns / 1ps
module rpsd_stddev_checker (
	input  logic clk,
	input  logic arst_n,
	rpsd_in_if in_ch,
	rpsd_out_if out_ch,
	output int fail_count,
	output int pending,
	output int results_seen
);
	import rpsd_pkg::*;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 1;

	longint unsigned members;
	logic [MEAN_W-1:0] mean_mem [POINTS_DEF];
	logic [SUM_W-1:0] spread_mem [POINTS_DEF];
	out_item_t expected_sd_q[$];

	function automatic logic [31:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bitv, rem;
		res = 0;
		rem = v;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[31:0];
	endfunction

	// Welford step on one point, n counts the member now being fed
	function automatic void welford_update(input logic [IDX_W-1:0] idx,
		input logic [31:0] sample);
		logic [63:0] n, ap, q, term, old_sum, new_sum;
		logic signed [63:0] xs, mean_v, pert, step, nm;
		logic [127:0] sq, t, quo;
		logic [64:0] acc;
		n = members + 1;
		xs = {{16{sample[31]}}, sample, 16'h0};
		mean_v = (n == 1) ? 64'sd0 : {{16{mean_mem[idx][47]}}, mean_mem[idx]};
		pert = xs - mean_v;
		ap = pert[63] ? 64'(-pert) : 64'(pert);
		if (n == 1) begin
			new_sum = 0;
		end else begin
			sq = {64'h0, ap} * {64'h0, ap};
			t = (sq >> 32) * {64'h0, n - 64'd1};
			quo = t / {64'h0, n};
			term = (quo[127:64] != 0) ? '1 : quo[63:0];
			old_sum = spread_mem[idx];
			acc = {1'b0, old_sum} + {1'b0, term};
			new_sum = acc[64] ? '1 : acc[63:0];
		end
		q = ap / n;
		step = pert[63] ? -$signed(q) : $signed(q);
		nm = mean_v + step;
		if (nm > 64'sh7FFFFFFFFFFF)
			nm = 64'sh7FFFFFFFFFFF;
		if (nm < -64'sh800000000000)
			nm = -64'sh800000000000;
		mean_mem[idx] = nm[47:0];
		spread_mem[idx] = new_sum;
	endfunction

	function automatic out_item_t stddev_of(input logic [IDX_W-1:0] idx);
		out_item_t r;
		logic [63:0] s;
		s = spread_mem[idx];
		r.result_index = idx;
		if (members < 2) begin
			r.std_dev = 0;
			r.status = ST_TOO_FEW;
		end else if (s == '1) begin
			r.std_dev = '1;
			r.status = ST_SAT;
		end else begin
			r.std_dev = int_sqrt(s / (members - 1));
			r.status = ST_OK;
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	assign pending = expected_sd_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			members = 0;
			fail_count = 0;
			results_seen = 0;
			expected_sd_q.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (expected_sd_q.size() == 0) begin
					report("unexpected beat, index", 32'(out_ch.result_index), 32'd0);
				end else begin
					e = expected_sd_q.pop_front();
					if (out_ch.std_dev !== e.std_dev)
						report("std_dev", out_ch.std_dev, e.std_dev);
					if (out_ch.result_index !== e.result_index)
						report("result_index", 32'(out_ch.result_index),
							32'(e.result_index));
					if (out_ch.status !== e.status)
						report("status", 32'(out_ch.status), 32'(e.status));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				unique case (cmd_t'(in_ch.command))
					CMD_UPDATE: begin
						welford_update(in_ch.point_index, in_ch.sample_value);
						if (in_ch.member_last && members < COUNT_MAX)
							members = members + 1;
					end
					CMD_READ: expected_sd_q = {expected_sd_q, stddev_of(in_ch.point_index)};
					CMD_RESTART: members = 0;
					default: ;
				endcase
			end
		end
	end
endmodule

// File: tb/tb_top.sv
// Testbench top: clock, reset, stimulus with idling and stalls, final verdict
`timescale 1ns / 1ps
module tb_top;
	import rpsd_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int TARGET_ITEMS = 900;

	logic clk;
	logic arst_n;
	rpsd_in_if in_ch();
	rpsd_out_if out_ch();
	int fail_count, pending, results_seen;

	running_pointwise_stddev_unit dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch));
	rpsd_stddev_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen));

	int items_sent, reads_sent, burst_left, cycles;
	bit no_gaps, hold_req;
	int unsigned members;
	bit written [POINTS_DEF];

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver: random stalls, quiet stretches, and one long hold on request
	initial begin
		int hold_left, mode_left;
		bit quiet;
		out_ch.ready = 0;
		hold_left = 0;
		mode_left = 0;
		quiet = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = 600;
				hold_req = 0;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				quiet = ($urandom_range(0, 2) == 0);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 0;
			end else begin
				out_ch.ready = quiet || ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic send(input cmd_t c, input logic [11:0] idx, input logic [31:0] s,
		input bit last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!no_gaps) begin
				in_ch.valid = 0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		in_ch.command = c;
		in_ch.point_index = idx;
		in_ch.sample_value = s;
		in_ch.member_last = last;
		in_ch.valid = 1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		case (c)
			CMD_UPDATE: begin
				written[idx] = 1;
				if (last && members < 65535)
					members++;
			end
			CMD_READ: reads_sent++;
			CMD_RESTART: members = 0;
			default: ;
		endcase
	endtask

	task automatic drain;
		in_ch.valid = 0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [11:0] pts [6];
		logic [31:0] base;
		int npts, nmem, k;
		bit narrow;
		in_ch.valid = 0;
		in_ch.command = CMD_UPDATE;
		in_ch.point_index = 0;
		in_ch.sample_value = 0;
		in_ch.member_last = 0;
		hold_req = 0;
		no_gaps = 0;
		burst_left = 0;
		items_sent = 0;
		reads_sent = 0;
		members = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, too few members, saturation of the spread sum
		send(CMD_RESTART, 12'hFFF, 32'hFFFFFFFF, 1);
		send(CMD_UPDATE, 12'h000, 32'h80000000, 0);
		send(CMD_UPDATE, 12'hFFF, 32'h7FFFFFFF, 1);
		send(CMD_READ, 12'h000, 32'h0, 0);
		send(CMD_NONE, 12'hABC, 32'h5A5A5A5A, 1);
		send(CMD_UPDATE, 12'h000, 32'h7FFFFFFF, 0);
		send(CMD_UPDATE, 12'hFFF, 32'h80000000, 1);
		send(CMD_READ, 12'h000, 32'h0, 0);
		send(CMD_READ, 12'hFFF, 32'h0, 0);
		for (int i = 0; i < 8; i++) begin
			send(CMD_UPDATE, 12'h000, i[0] ? 32'h7FFFFFFF : 32'h80000000, 1);
			if (i >= 5)
				send(CMD_READ, 12'h000, 32'h0, 0);
		end
		send(CMD_RESTART, 12'h555, 32'h0, 0);
		send(CMD_READ, 12'hFFF, 32'h0, 1);
		send(CMD_UPDATE, 12'h555, 32'h00000000, 1);
		send(CMD_UPDATE, 12'h555, 32'hFFFFFFFF, 1);
		send(CMD_READ, 12'h555, 32'h0, 0);
		drain();

		// random: member sequences with random content, plus noise
		while (items_sent < TARGET_ITEMS) begin
			if (items_sent > 300 && items_sent < 330 && !hold_req)
				hold_req = 1;
			if (items_sent > 600 && items_sent < 620) begin
				drain();
				no_gaps = ~no_gaps;
			end
			send(CMD_RESTART, 12'($urandom), $urandom, 1'($urandom_range(0, 1)));
			nmem = $urandom_range(1, 6);
			npts = $urandom_range(1, 6);
			narrow = $urandom_range(0, 2) != 0;
			base = $urandom;
			for (int p = 0; p < npts; p++)
				pts[p] = 12'($urandom);
			for (int m = 0; m < nmem; m++) begin
				for (int p = 0; p < npts; p++)
					send(CMD_UPDATE, pts[p],
						narrow ? base + $urandom_range(0, 4095) - 2048 : $urandom,
						p == npts - 1);
				if ($urandom_range(0, 3) == 0)
					send(CMD_READ, pts[$urandom_range(0, npts - 1)], $urandom, 0);
				if ($urandom_range(0, 9) == 0)
					send(CMD_NONE, 12'($urandom), $urandom, 1'($urandom_range(0, 1)));
				// broken sequence: restart in the middle
				if ($urandom_range(0, 14) == 0)
					send(CMD_RESTART, 12'($urandom), $urandom, 0);
			end
			for (int p = 0; p < npts; p++)
				send(CMD_READ, pts[p], $urandom, 1'($urandom_range(0, 1)));
			// stray reads on points already holding data, updates there or while no member is done
			for (int r = 0; r < 3; r++) begin
				k = $urandom_range(0, POINTS_DEF - 1);
				if (written[k] && $urandom_range(0, 1))
					send(CMD_READ, 12'(k), $urandom, 0);
				else if (written[k] || members == 0)
					send(CMD_UPDATE, 12'(k), $urandom, 0);
			end
		end
		drain();
		repeat (300) @(posedge clk);
		$display("sent %0d beats (%0d reads), checked %0d result beats",
			items_sent, reads_sent, results_seen);
		$display("covered member sequences, restarts, idle commands, saturation, stalls");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
